// ===== rtl/assert_macros.svh =====
// Assertion helpers for the RC4 block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ===== rtl/rc4_pkg.sv =====
package rc4_pkg;

   localparam logic [1:0] FUNC_LOAD  = 2'd0;
   localparam logic [1:0] FUNC_SCHED = 2'd1;
   localparam logic [1:0] FUNC_DATA  = 2'd2;

   localparam logic [8:0] KEY_LEN_RESET = 9'd128;
   localparam logic [7:0] LAST_STEP     = 8'hff;

   typedef enum logic [7:0] {
      ST_IDLE   = 8'b0000_0001,
      ST_D_J    = 8'b0000_0010,
      ST_D_T    = 8'b0000_0100,
      ST_D_OUT  = 8'b0000_1000,
      ST_K_RD   = 8'b0001_0000,
      ST_K_J    = 8'b0010_0000,
      ST_K_SW1  = 8'b0100_0000,
      ST_K_SW2  = 8'b1000_0000
   } state_type;

   typedef struct packed {
      logic       clear;
      logic       we;
      logic [7:0] waddr;
      logic [7:0] wdata;
      logic       re;
      logic [7:0] raddr;
   } perm_req_type;

endpackage

// ===== rtl/rc4_perm_mem.sv =====
module rc4_perm_mem (
   input  logic                 clock,
   input  logic                 reset,
   input  rc4_pkg::perm_req_type req,
   output logic [7:0]           rdata
);
   import rc4_pkg::*;

   logic [7:0] mem [256];
   logic [255:0] valid_ff;
   logic [255:0] valid_in;
   logic [7:0] rdata_ff;
   logic       rvalid_ff;
   logic [7:0] raddr_ff;

   always_comb begin
      valid_in = valid_ff;
      if (req.clear) begin
         valid_in = '0;
      end else if (req.we) begin
         valid_in[req.waddr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req.we) begin
         mem[req.waddr] <= req.wdata;
      end
      if (req.re) begin
         rdata_ff  <= mem[req.raddr];
         rvalid_ff <= valid_ff[req.raddr];
         raddr_ff  <= req.raddr;
      end
   end

   // an entry never written since the last clear reads as the identity
   assign rdata = rvalid_ff ? rdata_ff : raddr_ff;

endmodule

// ===== rtl/rc4_key_mem.sv =====
module rc4_key_mem #(
   parameter int DEPTH = 256,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic          clock,
   input  logic          we,
   input  logic [AW-1:0] waddr,
   input  logic [7:0]    wdata,
   input  logic          re,
   input  logic [AW-1:0] raddr,
   output logic [7:0]    rdata
);
   import rc4_pkg::*;

   logic [7:0] mem [DEPTH];
   logic [7:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ===== rtl/rc4_stream_cipher.sv =====
// RC4 stream cipher.
// Requests arrive on req_* (valid/ready); req_func selects a key byte load,
// a key schedule or a data byte. Only data requests give a response, on
// rsp_* (valid/ready), carrying data XOR the next keystream byte.
// The key length register is written through csr_wr_en / csr_wr_data.
// A key load or an ignored code completes on acceptance. A data request
// steps through ST_D_J, ST_D_T and ST_D_OUT, loading its response register
// in ST_D_OUT: three dependent reads of the permutation memory (S[i], S[j],
// S[S[i]+S[j]]), which has one read and one write port, with the swap
// written back in ST_D_T and ST_D_OUT. A key schedule runs 256 steps of
// read-read-write-write on the permutation memory, through the ST_K_* states.
// One request is in flight at a time; req_ready is high only between them.
// Reset restores the identity permutation at once (per-entry valid bits),
// clears both stream indices and sets the key length to 128. The key store
// holds no defined contents after reset.
// A data request that finds the response register still full holds in its
// last step; no request is taken until that response has been taken.
`include "assert_macros.svh"

module rc4_stream_cipher #(
   parameter int KEY_BYTES = 256
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [1:0] req_func,
   input  logic [7:0] req_key_index,
   input  logic [7:0] req_key_byte,
   input  logic [7:0] req_data_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_out_byte,
   input  logic       csr_wr_en,
   input  logic [8:0] csr_wr_data
);
   import rc4_pkg::*;

   localparam int KEY_AW = (KEY_BYTES > 1) ? $clog2(KEY_BYTES) : 1;
   localparam logic [8:0] KEY_BYTES_W = 9'(KEY_BYTES);

   state_type    state_ff, state_in;
   logic [8:0]   key_len_ff, key_len_in;
   logic [7:0]   i_ff, i_in;
   logic [7:0]   j_ff, j_in;
   logic [7:0]   k_ff, k_in;
   logic [KEY_AW-1:0] pos_ff, pos_in;
   logic [7:0]   si_ff, si_in;
   logic [7:0]   sj_ff, sj_in;
   logic [7:0]   t_ff, t_in;
   logic [7:0]   data_ff, data_in;
   logic         rsp_valid_ff, rsp_valid_in;
   logic [7:0]   rsp_byte_ff, rsp_byte_in;

   perm_req_type perm_req;
   logic [7:0]   perm_rdata;
   logic         key_we, key_re;
   logic [7:0]   key_rdata;

   logic         req_take;
   logic [8:0]   eff_len;
   logic [8:0]   pos_next;
   logic [7:0]   keystream;
   logic         rsp_free;

   rc4_perm_mem u_perm (
      .clock (clock),
      .reset (reset),
      .req   (perm_req),
      .rdata (perm_rdata)
   );

   rc4_key_mem #(
      .DEPTH (KEY_BYTES),
      .AW    (KEY_AW)
   ) u_key (
      .clock (clock),
      .we    (key_we),
      .waddr (req_key_index[KEY_AW-1:0]),
      .wdata (req_key_byte),
      .re    (key_re),
      .raddr (pos_ff),
      .rdata (key_rdata)
   );

   assign req_ready = (state_ff == ST_IDLE);
   assign req_take  = req_valid && req_ready;
   assign rsp_free  = !rsp_valid_ff || rsp_ready;

   assign key_we = req_take && (req_func == FUNC_LOAD) &&
                   ({1'b0, req_key_index} < KEY_BYTES_W);
   assign key_re = (state_ff == ST_K_RD);

   always_comb begin
      if (key_len_ff == 9'd0) begin
         eff_len = 9'd1;
      end else if (key_len_ff > KEY_BYTES_W) begin
         eff_len = KEY_BYTES_W;
      end else begin
         eff_len = key_len_ff;
      end
   end

   assign pos_next = {{(9 - KEY_AW){1'b0}}, pos_ff} + 9'd1;

   // the swap lands after the lookup read; take swapped values from registers
   always_comb begin
      if (t_ff == j_ff) begin
         keystream = si_ff;
      end else if (t_ff == i_ff) begin
         keystream = sj_ff;
      end else begin
         keystream = perm_rdata;
      end
   end

   always_comb begin
      state_in     = state_ff;
      key_len_in   = csr_wr_en ? csr_wr_data : key_len_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      k_in         = k_ff;
      pos_in       = pos_ff;
      si_in        = si_ff;
      sj_in        = sj_ff;
      t_in         = t_ff;
      data_in      = data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_byte_in  = rsp_byte_ff;
      perm_req     = '0;

      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               if (req_func == FUNC_DATA) begin
                  i_in           = i_ff + 8'd1;
                  perm_req.re    = 1'b1;
                  perm_req.raddr = i_ff + 8'd1;
                  data_in        = req_data_byte;
                  state_in       = ST_D_J;
               end else if (req_func == FUNC_SCHED) begin
                  perm_req.clear = 1'b1;
                  k_in           = 8'd0;
                  j_in           = 8'd0;
                  pos_in         = '0;
                  state_in       = ST_K_RD;
               end
            end
         end
         ST_D_J: begin
            si_in          = perm_rdata;
            j_in           = j_ff + perm_rdata;
            perm_req.re    = 1'b1;
            perm_req.raddr = j_ff + perm_rdata;
            state_in       = ST_D_T;
         end
         ST_D_T: begin
            sj_in          = perm_rdata;
            perm_req.we    = 1'b1;
            perm_req.waddr = i_ff;
            perm_req.wdata = perm_rdata;
            t_in           = si_ff + perm_rdata;
            perm_req.re    = 1'b1;
            perm_req.raddr = si_ff + perm_rdata;
            state_in       = ST_D_OUT;
         end
         ST_D_OUT: begin
            // rewrite is harmless while the response register is stalled
            perm_req.we    = 1'b1;
            perm_req.waddr = j_ff;
            perm_req.wdata = si_ff;
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_byte_in  = data_ff ^ keystream;
               state_in     = ST_IDLE;
            end
         end
         ST_K_RD: begin
            perm_req.re    = 1'b1;
            perm_req.raddr = k_ff;
            state_in       = ST_K_J;
         end
         ST_K_J: begin
            si_in          = perm_rdata;
            j_in           = j_ff + perm_rdata + key_rdata;
            perm_req.re    = 1'b1;
            perm_req.raddr = j_ff + perm_rdata + key_rdata;
            state_in       = ST_K_SW1;
         end
         ST_K_SW1: begin
            perm_req.we    = 1'b1;
            perm_req.waddr = k_ff;
            perm_req.wdata = perm_rdata;
            state_in       = ST_K_SW2;
         end
         ST_K_SW2: begin
            perm_req.we    = 1'b1;
            perm_req.waddr = j_ff;
            perm_req.wdata = si_ff;
            k_in           = k_ff + 8'd1;
            pos_in         = (pos_next >= eff_len) ? '0 : pos_next[KEY_AW-1:0];
            if (k_ff == LAST_STEP) begin
               i_in     = 8'd0;
               j_in     = 8'd0;
               state_in = ST_IDLE;
            end else begin
               state_in = ST_K_RD;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         key_len_ff   <= KEY_LEN_RESET;
         i_ff         <= 8'd0;
         j_ff         <= 8'd0;
         k_ff         <= 8'd0;
         pos_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         key_len_ff   <= key_len_in;
         i_ff         <= i_in;
         j_ff         <= j_in;
         k_ff         <= k_in;
         pos_ff       <= pos_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      si_ff       <= si_in;
      sj_ff       <= sj_in;
      t_ff        <= t_in;
      data_ff     <= data_in;
      rsp_byte_ff <= rsp_byte_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_out_byte = rsp_byte_ff;

   `ASSERT_SAME(a_rsp_from_last_step, clock, reset, $rose(rsp_valid_ff),
      $past(state_ff == ST_D_OUT))
   `ASSERT_NEXT(a_stall_holds_step, clock, reset,
      (state_ff == ST_D_OUT) && rsp_valid_ff && !rsp_ready, state_ff == ST_D_OUT)
   `ASSERT_NEXT(a_sched_clears_idx, clock, reset,
      (state_ff == ST_K_SW2) && (k_ff == LAST_STEP),
      (state_ff == ST_IDLE) && (i_ff == 8'd0) && (j_ff == 8'd0))
   `ASSERT_SAME(a_no_write_idle, clock, reset, state_ff == ST_IDLE, !perm_req.we)

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
   import rc4_pkg::*;

   localparam int         KEY_BYTES     = 256;
   localparam logic [1:0] FUNC_NONE     = 2'd3;
   localparam int         IDLE_PCT      = 29;
   localparam int         SETTLE_CYCLES = 1100;
   localparam int         STALL_CYCLES  = 400;
   localparam int         STALL_AT      = 500;
   localparam int         PHASE_ITEMS   = 205;
   localparam int         MAX_REPORTS   = 100;
   localparam int         CYCLE_LIMIT   = 1000000;

   typedef struct {
      logic [1:0] func;
      logic [7:0] key_index;
      logic [7:0] key_byte;
      logic [7:0] data_byte;
   } rc4_req_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic [1:0] req_func = FUNC_LOAD;
   logic [7:0] req_key_index = 8'd0;
   logic [7:0] req_key_byte = 8'd0;
   logic [7:0] req_data_byte = 8'd0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic [7:0] rsp_out_byte;
   logic       csr_wr_en = 1'b0;
   logic [8:0] csr_wr_data = 9'd0;

   // cipher state as the block should hold it
   logic [7:0] perm [256];
   logic [7:0] key_mem [256];
   logic [7:0] idx_i;
   logic [7:0] idx_j;
   logic [8:0] key_len = KEY_LEN_RESET;

   rc4_req_type pending_reqs [$];
   logic [7:0] cipher_expected [$];
   bit         key_loaded [256];
   int         planned_count = 0;
   int         accepted_count = 0;
   int         error_count = 0;
   int         cycle_count = 0;
   int         stall_left = 0;
   bit         stall_done = 1'b0;
   logic       req_taken = 1'b0;
   logic       calm;

   assign calm = accepted_count >= 900 && accepted_count < 1200;

   rc4_stream_cipher u_dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_func      (req_func),
      .req_key_index (req_key_index),
      .req_key_byte  (req_key_byte),
      .req_data_byte (req_data_byte),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_out_byte  (rsp_out_byte),
      .csr_wr_en     (csr_wr_en),
      .csr_wr_data   (csr_wr_data)
   );

   always #5 clock = ~clock;

   function automatic int key_span(logic [8:0] len);
      if (len == 9'd0)
         return 1;
      if (len > KEY_BYTES)
         return KEY_BYTES;
      return int'(len);
   endfunction

   function automatic void rebuild_perm();
      int         span;
      int         pos;
      logic [7:0] j;
      logic [7:0] t;
      span = key_span(key_len);
      pos = 0;
      j = 8'd0;
      for (int k = 0; k < 256; k++)
         perm[k] = k[7:0];
      for (int k = 0; k < 256; k++) begin
         j = j + perm[k] + key_mem[pos];
         t = perm[k];
         perm[k] = perm[j];
         perm[j] = t;
         pos++;
         if (pos >= span)
            pos = 0;
      end
      idx_i = 8'd0;
      idx_j = 8'd0;
   endfunction

   function automatic logic [7:0] draw_keystream();
      logic [7:0] t;
      idx_i = idx_i + 8'd1;
      idx_j = idx_j + perm[idx_i];
      t = perm[idx_i];
      perm[idx_i] = perm[idx_j];
      perm[idx_j] = t;
      t = perm[idx_i] + perm[idx_j];
      return perm[t];
   endfunction

   function automatic void advance_cipher(rc4_req_type r);
      case (r.func)
         FUNC_LOAD:  key_mem[r.key_index] = r.key_byte;
         FUNC_SCHED: rebuild_perm();
         FUNC_DATA:  cipher_expected.push_back(r.data_byte ^ draw_keystream());
         default: ;
      endcase
   endfunction

   function automatic void queue_req(logic [1:0] func, logic [7:0] key_index,
                                     logic [7:0] key_byte, logic [7:0] data_byte);
      pending_reqs.push_back('{func, key_index, key_byte, data_byte});
      if (func == FUNC_LOAD)
         key_loaded[key_index] = 1'b1;
      if (func != FUNC_NONE)
         planned_count++;
   endfunction

   // fill any key bytes the schedule would read, often rekey, schedule, then stream
   task automatic queue_session(int n_data);
      int span;
      int n_rekey;
      int r;
      span = key_span(key_len);
      for (int k = 0; k < span; k++)
         if (!key_loaded[k])
            queue_req(FUNC_LOAD, k[7:0], 8'($urandom), 8'($urandom));
      if ($urandom_range(9) != 0) begin
         n_rekey = $urandom_range(1, span < 12 ? span : 12);
         for (int k = 0; k < n_rekey; k++)
            queue_req(FUNC_LOAD, 8'($urandom_range(span - 1)), 8'($urandom),
                      8'($urandom));
      end
      if ($urandom_range(3) == 0)
         queue_req(FUNC_LOAD, 8'($urandom), 8'($urandom), 8'($urandom));
      queue_req(FUNC_SCHED, 8'($urandom), 8'($urandom), 8'($urandom));
      if ($urandom_range(9) == 0)
         queue_req(FUNC_SCHED, 8'($urandom), 8'($urandom), 8'($urandom));
      for (int k = 0; k < n_data; k++) begin
         r = $urandom_range(99);
         if (r < 4)
            queue_req(FUNC_NONE, 8'($urandom), 8'($urandom), 8'($urandom));
         else if (r < 7)
            queue_req(FUNC_LOAD, 8'($urandom), 8'($urandom), 8'($urandom));
         queue_req(FUNC_DATA, 8'($urandom), 8'($urandom), 8'($urandom));
      end
   endtask

   // hold off until every request is through, then let a key schedule finish
   task automatic wait_drained();
      @(posedge clock);
      while (pending_reqs.size() != 0 || req_valid || cipher_expected.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_key_length(logic [8:0] len);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= len;
      key_len = len;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      @(posedge clock);
   endtask

   task automatic queue_phase();
      int target;
      target = planned_count + PHASE_ITEMS;
      while (planned_count < target)
         queue_session($urandom_range(4, 40));
   endtask

   initial begin
      logic [8:0] key_settings [7];
      for (int k = 0; k < 256; k++) begin
         perm[k] = k[7:0];
         key_loaded[k] = 1'b0;
      end
      idx_i = 8'd0;
      idx_j = 8'd0;
      key_settings = '{9'd1, 9'd511, 9'd256, 9'd257, 9'd2, 9'd2, 9'd2};
      key_settings[4] = 9'($urandom_range(3, 40));
      key_settings[5] = 9'($urandom_range(41, 255));

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // stream from the identity permutation, unused code, key store extremes
      queue_req(FUNC_DATA, 8'h00, 8'h00, 8'h00);
      queue_req(FUNC_DATA, 8'hff, 8'hff, 8'hff);
      queue_req(FUNC_NONE, 8'hff, 8'hff, 8'hff);
      queue_req(FUNC_DATA, 8'h00, 8'h00, 8'h3c);
      queue_req(FUNC_LOAD, 8'h00, 8'hff, 8'h00);
      queue_req(FUNC_LOAD, 8'hff, 8'h00, 8'hff);
      queue_req(FUNC_LOAD, 8'h7f, 8'h80, 8'h55);
      // key length as it comes out of reset
      queue_phase();

      // zero key length behaves as one; a second schedule restarts the stream
      wait_drained();
      write_key_length(9'd0);
      queue_req(FUNC_SCHED, 8'h00, 8'h00, 8'h00);
      queue_req(FUNC_DATA, 8'h00, 8'h00, 8'h00);
      queue_req(FUNC_DATA, 8'h00, 8'h00, 8'hff);
      queue_req(FUNC_DATA, 8'h00, 8'h00, 8'ha5);
      queue_req(FUNC_NONE, 8'h00, 8'h00, 8'h00);
      queue_req(FUNC_DATA, 8'h00, 8'h00, 8'h5a);
      queue_req(FUNC_SCHED, 8'hff, 8'hff, 8'hff);
      queue_req(FUNC_DATA, 8'h00, 8'h00, 8'h00);
      queue_req(FUNC_DATA, 8'h00, 8'h00, 8'hff);

      foreach (key_settings[p]) begin
         wait_drained();
         write_key_length(key_settings[p]);
         queue_phase();
      end

      wait_drained();
      if (error_count == 0)
         $display("testbench: done, clean");
      else
         $display("testbench: done, errors");
      $finish;
   end

   always @(negedge clock) begin : req_driver
      rc4_req_type next_req;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (pending_reqs.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
            next_req = pending_reqs.pop_front();
            req_valid <= 1'b1;
            req_func <= next_req.func;
            req_key_index <= next_req.key_index;
            req_key_byte <= next_req.key_byte;
            req_data_byte <= next_req.data_byte;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // one long hold on responses while requests keep coming
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (stall_left != 0) begin
         rsp_ready <= 1'b0;
         stall_left <= stall_left - 1;
      end else if (!stall_done && accepted_count >= STALL_AT && pending_reqs.size() > 40) begin
         stall_done <= 1'b1;
         stall_left <= STALL_CYCLES;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= calm || $urandom_range(99) >= IDLE_PCT;
      end
   end

   always @(posedge clock) begin : monitor
      logic [7:0] want;
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (cipher_expected.size() == 0) begin
               if (error_count < MAX_REPORTS)
                  $error("out_byte: no response expected, got %h", rsp_out_byte);
               error_count++;
            end else begin
               want = cipher_expected.pop_front();
               if (rsp_out_byte !== want) begin
                  if (error_count < MAX_REPORTS)
                     $error("out_byte: expected %h, got %h", want, rsp_out_byte);
                  error_count++;
               end
            end
         end
         if (req_valid && req_ready) begin
            advance_cipher('{req_func, req_key_index, req_key_byte, req_data_byte});
            if (req_func != FUNC_NONE)
               accepted_count++;
         end
         req_taken <= req_valid && req_ready;
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("testbench: done, errors");
         $finish;
      end
   end

endmodule

// ===== rc4_stream_cipher.f =====
+incdir+rtl
rtl/rc4_pkg.sv
rtl/rc4_perm_mem.sv
rtl/rc4_key_mem.sv
rtl/rc4_stream_cipher.sv
tb/testbench.sv
